FILE: rtl/barometric_letter_forecast_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric letter forecaster
// Concurrent checks, clocked on clk and disabled during rst; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_LETTER_FORECAST_ASSERT_SVH
`define BAROMETRIC_LETTER_FORECAST_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must never hold
`define BLF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
// Same-cycle implication
`define BLF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define BLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BLF_ASSERT_NEVER(label, cond, msg)
`define BLF_ASSERT_IMPLIES(label, ante, cons, msg)
`define BLF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/blf_pkg.sv
// ----------------------------------------------------------------------------
// blf_pkg
// Types, constants and lookup tables shared by the barometric letter forecaster.
// ----------------------------------------------------------------------------
package blf_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 14;
  localparam logic [CFG_INDEX_W-1:0] REG_HEMISPHERE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  THRESHOLD_RESET = 14'd10;

  // Pressure limits and corrections, 0.01 hPa
  localparam logic [16:0] P_LOW       = 17'd95000;
  localparam logic [16:0] P_HIGH      = 17'd105000;
  localparam logic [17:0] SEASON_STEP = 18'd320;

  // Wind sectors, tenths of a degree
  localparam logic [11:0] FULL_TURN    = 12'd3600;
  localparam int          SECTORS      = 16;
  localparam int          SECTOR_WIDTH = 225;
  localparam int          SECTOR_HALF  = 112;

  // Linear index: idx = floor((coef * (centre - p) + HALF) / SCALE)
  localparam int IDX_SCALE = 1000000;
  localparam int IDX_HALF  = 500000;

  localparam int RISE_COEF     = 1740;
  localparam int RISE_CENTRE   = 103140;
  localparam int RISE_ENTRIES  = 14;
  localparam int FALL_COEF     = 1553;
  localparam int FALL_CENTRE   = 102995;
  localparam int FALL_ENTRIES  = 10;
  localparam int STEADY_COEF   = 2314;
  localparam int STEADY_CENTRE = 103081;
  localparam int STEADY_ENTRIES = 17;

  typedef enum logic [1:0] {
    CLASS_STEADY  = 2'd0,
    CLASS_RISING  = 2'd1,
    CLASS_FALLING = 2'd2
  } trend_class_t;

  typedef struct packed {
    logic [17:0]        pressure_centi_hpa;
    logic               pressure_ok;
    logic signed [15:0] trend_centi_hpa_h;
    logic               trend_ok;
    logic [3:0]         month_number;
    logic               month_ok;
    logic [11:0]        wind_dir_decideg;
    logic               wind_ok;
  } in_item_t;

  typedef struct packed {
    logic        forecast_ok;
    logic [4:0]  letter_index;
    logic [1:0]  trend_class;
    logic [16:0] adjusted_centi_hpa;
    logic        wind_applied;
    logic        season_applied;
  } out_item_t;

  typedef struct packed {
    logic               applied;
    logic signed [11:0] adj;
  } wind_res_t;

  // Wind correction per sector, 0.01 hPa
  function automatic logic signed [11:0] wind_adj(input logic [3:0] sec);
    logic signed [11:0] v;
    case (sec)
      4'd0:    v = 12'sd520;
      4'd1:    v = 12'sd420;
      4'd2:    v = 12'sd320;
      4'd3:    v = 12'sd105;
      4'd4:    v = -12'sd110;
      4'd5:    v = -12'sd315;
      4'd6:    v = -12'sd520;
      4'd7:    v = -12'sd835;
      4'd8:    v = -12'sd1150;
      4'd9:    v = -12'sd940;
      4'd10:   v = -12'sd730;
      4'd11:   v = -12'sd525;
      4'd12:   v = -12'sd320;
      4'd13:   v = -12'sd115;
      4'd14:   v = 12'sd90;
      4'd15:   v = 12'sd305;
      default: v = 12'sd0;
    endcase
    return v;
  endfunction

  // Highest pressure that still reaches index k (k >= 1)
  function automatic int rise_limit(input int k);
    return RISE_CENTRE - (k * IDX_SCALE - IDX_HALF + RISE_COEF - 1) / RISE_COEF;
  endfunction

  function automatic int fall_limit(input int k);
    return FALL_CENTRE - (k * IDX_SCALE - IDX_HALF + FALL_COEF - 1) / FALL_COEF;
  endfunction

  function automatic int steady_limit(input int k);
    return STEADY_CENTRE - (k * IDX_SCALE - IDX_HALF + STEADY_COEF - 1) / STEADY_COEF;
  endfunction

  function automatic logic [4:0] rise_letter(input logic [3:0] idx);
    logic [4:0] v;
    case (idx)
      4'd0:    v = 5'd0;
      4'd1:    v = 5'd1;
      4'd2:    v = 5'd1;
      4'd3:    v = 5'd2;
      4'd4:    v = 5'd5;
      4'd5:    v = 5'd6;
      4'd6:    v = 5'd8;
      4'd7:    v = 5'd9;
      4'd8:    v = 5'd11;
      4'd9:    v = 5'd12;
      4'd10:   v = 5'd12;
      4'd11:   v = 5'd16;
      4'd12:   v = 5'd19;
      4'd13:   v = 5'd24;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] fall_letter(input logic [3:0] idx);
    logic [4:0] v;
    case (idx)
      4'd0:    v = 5'd1;
      4'd1:    v = 5'd3;
      4'd2:    v = 5'd7;
      4'd3:    v = 5'd14;
      4'd4:    v = 5'd17;
      4'd5:    v = 5'd20;
      4'd6:    v = 5'd21;
      4'd7:    v = 5'd23;
      4'd8:    v = 5'd23;
      4'd9:    v = 5'd25;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] steady_letter(input logic [4:0] idx);
    logic [4:0] v;
    case (idx)
      5'd0:    v = 5'd0;
      5'd1:    v = 5'd1;
      5'd2:    v = 5'd1;
      5'd3:    v = 5'd1;
      5'd4:    v = 5'd4;
      5'd5:    v = 5'd10;
      5'd6:    v = 5'd13;
      5'd7:    v = 5'd13;
      5'd8:    v = 5'd15;
      5'd9:    v = 5'd15;
      5'd10:   v = 5'd18;
      5'd11:   v = 5'd22;
      5'd12:   v = 5'd22;
      5'd13:   v = 5'd23;
      5'd14:   v = 5'd23;
      5'd15:   v = 5'd23;
      5'd16:   v = 5'd25;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/blf_wind.sv
// ----------------------------------------------------------------------------
// blf_wind
// Maps wind direction to one of 16 sectors and returns its pressure correction.
// ----------------------------------------------------------------------------
module blf_wind
  import blf_pkg::*;
(
  input  logic [11:0] wind_dir_decideg,
  input  logic        wind_ok,
  input  logic        northern,
  output wind_res_t   res
);

  logic [11:0]        dir_wrapped;
  logic [SECTORS-1:0] thermo;
  logic [4:0]         sector_count;
  logic [3:0]         sector;

  // Wrap directions of a full turn or more
  assign dir_wrapped = (wind_dir_decideg >= FULL_TURN) ? (wind_dir_decideg - FULL_TURN)
                                                       : wind_dir_decideg;

  // Sector boundaries sit half a sector off the compass points
  always_comb begin
    for (int k = 1; k <= SECTORS; k++) begin
      thermo[k-1] = (int'(dir_wrapped) >= (SECTOR_WIDTH * k - SECTOR_HALF));
    end
  end

  assign sector_count = 5'($countones(thermo));

  // Wrap sector 16 to 0; move half a turn in the southern hemisphere
  assign sector = sector_count[3:0] ^ {!northern, 3'b000};

  assign res.applied = wind_ok;
  assign res.adj     = wind_ok ? wind_adj(sector) : 12'sd0;

endmodule

FILE: rtl/blf_letter.sv
// ----------------------------------------------------------------------------
// blf_letter
// Turns adjusted pressure and trend class into a forecast letter.
// ----------------------------------------------------------------------------
module blf_letter
  import blf_pkg::*;
(
  input  logic [16:0]  pressure,
  input  trend_class_t trend_class,
  output logic [4:0]   letter_index
);

  logic [RISE_ENTRIES-2:0]   rise_thermo;
  logic [FALL_ENTRIES-2:0]   fall_thermo;
  logic [STEADY_ENTRIES-2:0] steady_thermo;
  logic [3:0]                rise_idx;
  logic [3:0]                fall_idx;
  logic [4:0]                steady_idx;

  // Compare against the pressure limit of every index step; the limits fall
  // with k, so the count of passed limits is the clamped index
  always_comb begin
    for (int k = 1; k < RISE_ENTRIES; k++) begin
      rise_thermo[k-1] = (int'(pressure) <= rise_limit(k));
    end
    for (int k = 1; k < FALL_ENTRIES; k++) begin
      fall_thermo[k-1] = (int'(pressure) <= fall_limit(k));
    end
    for (int k = 1; k < STEADY_ENTRIES; k++) begin
      steady_thermo[k-1] = (int'(pressure) <= steady_limit(k));
    end
  end

  assign rise_idx   = 4'($countones(rise_thermo));
  assign fall_idx   = 4'($countones(fall_thermo));
  assign steady_idx = 5'($countones(steady_thermo));

  // Pick the table of the trend class
  always_comb begin
    case (trend_class)
      CLASS_RISING:  letter_index = rise_letter(rise_idx);
      CLASS_FALLING: letter_index = fall_letter(fall_idx);
      CLASS_STEADY:  letter_index = steady_letter(steady_idx);
      default:       letter_index = 5'd0;
    endcase
  end

endmodule

FILE: rtl/barometric_letter_forecast.sv
// ----------------------------------------------------------------------------
// barometric_letter_forecast
// Zambretti-style forecast letter from pressure, trend, month and wind.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_valid/in_ready/in_data, results leave on
//   out_valid/out_ready/out_data; a transaction completes when valid and
//   ready are both high at a rising edge of clk.
//   The block has an input register and a result register with the whole
//   computation between them: a result shows on out_valid once it moves from
//   the input register into the result register, and one item is taken every
//   cycle while the receiver keeps out_ready high.
//   If the receiver stalls, the result register holds and the input register
//   fills; in_ready drops only when both are occupied, and nothing is lost.
//   Configuration goes through cfg_write/cfg_index/cfg_data, taken at once,
//   and should only be written while no transaction is in flight.
//   Synchronous reset empties both registers and restores northern
//   hemisphere and a trend threshold of 0.10 hPa/h.
// ----------------------------------------------------------------------------
`include "barometric_letter_forecast_assert.svh"

module barometric_letter_forecast
  import blf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                  northern;
  logic [CFG_DATA_W-1:0] threshold;

  logic      s1_valid;
  in_item_t  s1_data;
  logic      out_advance;

  logic                pressure_usable;
  logic [16:0]         p_clamp;
  wind_res_t           wind_res;
  logic signed [16:0]  trend_ext;
  logic signed [16:0]  thr_pos;
  logic signed [16:0]  thr_neg;
  trend_class_t        cls;
  logic                summer;
  logic                season_used;
  logic [17:0]         p_sum;
  logic [16:0]         p_adj;
  logic [4:0]          letter;
  out_item_t           result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      northern  <= 1'b1;
      threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEMISPHERE: northern  <= cfg_data[0];
        REG_THRESHOLD:  threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_advance = !out_valid || out_ready;
  assign in_ready    = !s1_valid || out_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Clamp pressure to the table range
  always_comb begin
    if (s1_data.pressure_centi_hpa < {1'b0, P_LOW}) begin
      p_clamp = P_LOW;
    end else if (s1_data.pressure_centi_hpa > {1'b0, P_HIGH}) begin
      p_clamp = P_HIGH;
    end else begin
      p_clamp = s1_data.pressure_centi_hpa[16:0];
    end
  end

  blf_wind u_wind (
    .wind_dir_decideg (s1_data.wind_dir_decideg),
    .wind_ok          (s1_data.wind_ok),
    .northern         (northern),
    .res              (wind_res)
  );

  // Classify the trend against the signed threshold
  assign trend_ext = {s1_data.trend_centi_hpa_h[15], s1_data.trend_centi_hpa_h};
  assign thr_pos   = $signed({3'b000, threshold});
  assign thr_neg   = -thr_pos;

  always_comb begin
    if (trend_ext >= thr_pos) begin
      cls = CLASS_RISING;
    end else if (trend_ext <= thr_neg) begin
      cls = CLASS_FALLING;
    end else begin
      cls = CLASS_STEADY;
    end
  end

  // Summer half-year depends on hemisphere; invalid months never count
  always_comb begin
    summer = 1'b0;
    if (s1_data.month_ok && (s1_data.month_number inside {[4'd1:4'd12]})) begin
      summer = northern ? (s1_data.month_number inside {[4'd4:4'd9]})
                        : !(s1_data.month_number inside {[4'd4:4'd9]});
    end
  end

  assign season_used = summer && (cls != CLASS_STEADY);

  // Add wind and season corrections
  always_comb begin
    p_sum = {1'b0, p_clamp} + {{6{wind_res.adj[11]}}, wind_res.adj};
    if (season_used && (cls == CLASS_RISING)) begin
      p_sum = p_sum + SEASON_STEP;
    end else if (season_used) begin
      p_sum = p_sum - SEASON_STEP;
    end
  end

  assign p_adj = p_sum[16:0];

  blf_letter u_letter (
    .pressure     (p_adj),
    .trend_class  (cls),
    .letter_index (letter)
  );

  // Zero the whole result when pressure or trend is unusable
  assign pressure_usable = s1_data.pressure_ok && s1_data.trend_ok;

  always_comb begin
    result = '0;
    if (pressure_usable) begin
      result.forecast_ok        = 1'b1;
      result.letter_index       = letter;
      result.trend_class        = cls;
      result.adjusted_centi_hpa = p_adj;
      result.wind_applied       = wind_res.applied;
      result.season_applied     = season_used;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      out_data <= result;
    end
  end

  // Checks
  `BLF_ASSERT_IMPLIES(a_unusable_zero, out_valid && !out_data.forecast_ok,
                      out_data == '0, "unusable reading left nonzero fields")
  `BLF_ASSERT_IMPLIES(a_steady_no_season,
                      out_valid && (out_data.trend_class == CLASS_STEADY),
                      !out_data.season_applied, "season correction on steady trend")
  `BLF_ASSERT_IMPLIES(a_adjusted_range, out_valid && out_data.forecast_ok,
                      (out_data.adjusted_centi_hpa >= 17'd93530) &&
                      (out_data.adjusted_centi_hpa <= 17'd105840),
                      "adjusted pressure out of range")
  `BLF_ASSERT_NEXT(a_stage_hold, s1_valid && !out_advance,
                   s1_valid && $stable(s1_data), "input stage lost item under stall")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: barometric_letter_forecast regression
// Drives pressure/trend/month/wind readings through the valid/ready input,
// predicts each forecast in the bench and checks every output transaction
// field by field, in order. Directed corner readings come first, then a
// receiver hold-off that fills the block, then random readings over several
// hemisphere/threshold settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import blf_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Bench copy of the configuration registers, at their reset values
  logic                   north_hemi   = 1'b1;
  logic [CFG_DATA_W-1:0]  trend_thresh = 14'd10;

  out_item_t forecast_queue[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        hold_request   = 0;
  logic      rx_random      = 1'b1;

  // Wind correction per 22.5 degree sector, 0.01 hPa
  int wind_shift [16] = '{520, 420, 320, 105, -110, -315, -520, -835,
                          -1150, -940, -730, -525, -320, -115, 90, 305};

  barometric_letter_forecast u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("barometric_letter_forecast regression: fail");
      $finish;
    end
  end

  // Compute the forecast the block should give for one reading
  function automatic out_item_t forecast_for(input in_item_t r);
    out_item_t   res;
    longint      p, trend, thr, coef, centre, num, idx;
    int unsigned d, sector;
    logic        north_summer, summer;
    string       letters;
    res = '0;
    if (!r.pressure_ok || !r.trend_ok)
      return res;
    p = longint'(r.pressure_centi_hpa);
    if (p < 95000) p = 95000;
    if (p > 105000) p = 105000;
    if (r.wind_ok) begin
      d = r.wind_dir_decideg % 3600;
      sector = ((2 * d + 225) / 450) % 16;
      if (!north_hemi)
        sector = (sector + 8) % 16;
      p = p + longint'(wind_shift[sector]);
      res.wind_applied = 1'b1;
    end
    north_summer = (r.month_number >= 4) && (r.month_number <= 9);
    summer = r.month_ok && (r.month_number >= 1) && (r.month_number <= 12) &&
             (north_hemi ? north_summer : !north_summer);
    trend = longint'(r.trend_centi_hpa_h);
    thr = longint'(trend_thresh);
    if (trend >= thr) begin
      res.trend_class = CLASS_RISING;
      if (summer) begin
        p = p + 320;
        res.season_applied = 1'b1;
      end
      coef = 1740; centre = 103140; letters = "ABBCFGIJLMMQTY";
    end else if (trend <= -thr) begin
      res.trend_class = CLASS_FALLING;
      if (summer) begin
        p = p - 320;
        res.season_applied = 1'b1;
      end
      coef = 1553; centre = 102995; letters = "BDHORUVXXZ";
    end else begin
      res.trend_class = CLASS_STEADY;
      coef = 2314; centre = 103081; letters = "ABBBEKNNPPSWWXXXZ";
    end
    // Round the scaled index half up, then clamp into the letter table
    num = 2 * coef * (centre - p) + 1000000;
    idx = (num < 0) ? 0 : num / 2000000;
    if (idx >= longint'(letters.len()))
      idx = longint'(letters.len() - 1);
    res.letter_index = 5'(letters[idx] - "A");
    res.adjusted_centi_hpa = p[16:0];
    res.forecast_ok = 1'b1;
    return res;
  endfunction

  function automatic in_item_t make_reading(input int p, input int p_ok, input int trend,
                                            input int t_ok, input int month, input int m_ok,
                                            input int wind, input int w_ok);
    in_item_t r;
    r.pressure_centi_hpa = 18'(p);
    r.pressure_ok        = (p_ok != 0);
    r.trend_centi_hpa_h  = 16'(trend);
    r.trend_ok           = (t_ok != 0);
    r.month_number       = 4'(month);
    r.month_ok           = (m_ok != 0);
    r.wind_dir_decideg   = 12'(wind);
    r.wind_ok            = (w_ok != 0);
    return r;
  endfunction

  // Mostly plausible weather, some full-range noise and unusable flags
  function automatic in_item_t random_reading();
    in_item_t    r;
    int unsigned pick;
    r.pressure_ok = ($urandom_range(0, 19) != 0);
    r.trend_ok    = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 9) == 0)
      r.pressure_centi_hpa = 18'($urandom_range(0, 262143));
    else
      r.pressure_centi_hpa = 18'($urandom_range(93000, 107000));
    pick = $urandom_range(0, 9);
    if (pick == 0)
      r.trend_centi_hpa_h = 16'($urandom_range(0, 65535));
    else if (pick < 4)
      r.trend_centi_hpa_h = 16'($urandom_range(0, 80) - 40);
    else
      r.trend_centi_hpa_h = 16'($urandom_range(0, 800) - 400);
    r.month_number = 4'($urandom_range(0, 15));
    r.month_ok     = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 7) == 0)
      r.wind_dir_decideg = 12'($urandom_range(0, 4095));
    else
      r.wind_dir_decideg = 12'($urandom_range(0, 3599));
    r.wind_ok = ($urandom_range(0, 7) != 0);
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one reading, hold it until taken, record its forecast
  task automatic send_reading(input in_item_t reading, input int gap);
    in_data  <= reading;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    forecast_queue.push_back(forecast_for(reading));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every forecast to come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (forecast_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles
  task automatic set_config(input logic hemi, input logic [CFG_DATA_W-1:0] thr);
    cfg_write <= 1'b1;
    cfg_index <= REG_HEMISPHERE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, hemi};
    @(posedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_write <= 1'b0;
    north_hemi   = hemi;
    trend_thresh = thr;
  endtask

  // Field extremes and corner cases under the reset configuration
  task automatic check_directed_defaults();
    in_item_t list[$];
    // pressure clamp at both ends, steady trend
    list.push_back(make_reading(0, 1, 0, 1, 1, 1, 0, 0));
    list.push_back(make_reading(262143, 1, 0, 1, 1, 1, 0, 0));
    // extreme trends in summer, wind north and south
    list.push_back(make_reading(101325, 1, 32767, 1, 6, 1, 0, 1));
    list.push_back(make_reading(101325, 1, -32768, 1, 7, 1, 1800, 1));
    // unusable pressure or trend
    list.push_back(make_reading(101325, 0, 500, 1, 6, 1, 900, 1));
    list.push_back(make_reading(101325, 1, 500, 0, 6, 1, 900, 1));
    list.push_back(make_reading(262143, 0, -1, 0, 15, 1, 4095, 1));
    // wind past a full turn and sector edges
    list.push_back(make_reading(100000, 1, 0, 1, 2, 1, 4095, 1));
    list.push_back(make_reading(100000, 1, 0, 1, 2, 1, 3600, 1));
    list.push_back(make_reading(100000, 1, 0, 1, 2, 1, 3599, 1));
    list.push_back(make_reading(100000, 1, 0, 1, 2, 1, 112, 1));
    list.push_back(make_reading(100000, 1, 0, 1, 2, 1, 113, 1));
    // months outside the calendar, month flag off
    list.push_back(make_reading(100000, 1, 500, 1, 0, 1, 0, 0));
    list.push_back(make_reading(100000, 1, 500, 1, 13, 1, 0, 0));
    list.push_back(make_reading(100000, 1, -500, 1, 15, 1, 0, 0));
    list.push_back(make_reading(100000, 1, 500, 1, 4, 0, 0, 0));
    // index below the table and past its end
    list.push_back(make_reading(105000, 1, 500, 1, 1, 0, 0, 0));
    list.push_back(make_reading(95000, 1, 500, 1, 1, 0, 0, 0));
    list.push_back(make_reading(95000, 1, -500, 1, 1, 0, 0, 0));
    list.push_back(make_reading(95000, 1, 0, 1, 1, 0, 0, 0));
    // trend right at the threshold
    list.push_back(make_reading(102000, 1, 10, 1, 5, 1, 0, 0));
    list.push_back(make_reading(102000, 1, -10, 1, 5, 1, 0, 0));
    list.push_back(make_reading(102000, 1, 9, 1, 5, 1, 0, 0));
    list.push_back(make_reading(102000, 1, -9, 1, 5, 1, 0, 0));
    foreach (list[i])
      send_reading(list[i], pick_gap());
    wait_idle();
  endtask

  // Zero threshold and southern hemisphere
  task automatic check_south_zero_threshold();
    set_config(1'b0, 14'd0);
    send_reading(make_reading(101000, 1, 0, 1, 1, 1, 0, 1), pick_gap());
    send_reading(make_reading(101000, 1, -1, 1, 6, 1, 1800, 1), pick_gap());
    send_reading(make_reading(101000, 1, 1, 1, 12, 1, 2700, 1), 0);
    wait_idle();
  endtask

  // Hold the receiver off while readings keep coming, so the block stalls
  task automatic check_backpressure();
    int n;
    set_config(1'b1, 14'd25);
    hold_request = 150;
    for (n = 0; n < 40; n++)
      send_reading(random_reading(), 0);
    wait_idle();
  endtask

  // Random readings across several register settings
  task automatic check_random_phases();
    int                    phase, n;
    logic                  hemi;
    logic [CFG_DATA_W-1:0] thr;
    logic                  tx_random;
    tx_random = 1'b1;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       begin hemi = 1'b1; thr = 14'd10; end
        1:       begin hemi = 1'b0; thr = 14'd0; end
        2:       begin hemi = 1'b1; thr = 14'd10000; end
        3:       begin hemi = 1'b0; thr = 14'd16383; end
        4:       begin hemi = 1'b1; thr = 14'd0; end
        5:       begin hemi = 1'b0; thr = 14'($urandom_range(0, 200)); end
        6:       begin hemi = 1'b1; thr = 14'($urandom_range(0, 16383)); end
        default: begin hemi = 1'b0; thr = 14'd10; end
      endcase
      set_config(hemi, thr);
      for (n = 0; n < 200; n++) begin
        // Switch idling on and off in stretches
        if (n % 50 == 0) begin
          tx_random = ($urandom_range(0, 3) != 0);
          rx_random = ($urandom_range(0, 3) != 0);
        end
        send_reading(random_reading(), tx_random ? pick_gap() : 0);
      end
      wait_idle();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        hold_request = hold_request - 1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = rx_random ? pick_gap() : 0;
      end
    end
  end

  // Check each output transaction against the oldest expected forecast
  always @(posedge clk) begin : forecast_check
    out_item_t want;
    logic      bad;
    if (!rst && out_valid && out_ready) begin
      if (forecast_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0d: unexpected forecast %p", cycle_count, out_data);
      end else begin
        want = forecast_queue.pop_front();
        bad = (out_data.forecast_ok        !== want.forecast_ok)        ||
              (out_data.letter_index       !== want.letter_index)       ||
              (out_data.trend_class        !== want.trend_class)        ||
              (out_data.adjusted_centi_hpa !== want.adjusted_centi_hpa) ||
              (out_data.wind_applied       !== want.wind_applied)       ||
              (out_data.season_applied     !== want.season_applied);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0d: forecast mismatch: expected %p got %p",
                     cycle_count, want, out_data);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    check_directed_defaults();
    check_south_zero_threshold();
    check_backpressure();
    check_random_phases();
    if (mismatch_count == 0)
      $display("barometric_letter_forecast regression: pass");
    else
      $display("barometric_letter_forecast regression: fail");
    $finish;
  end

endmodule

FILE: barometric_letter_forecast.f
+incdir+rtl
rtl/blf_pkg.sv
rtl/blf_wind.sv
rtl/blf_letter.sv
rtl/barometric_letter_forecast.sv
verif/tb_top.sv
